// File: design/ggt_pkg.sv
// ============================================================================
// ggt_pkg
// Shared widths, register codes, entry tables and helpers of the point-mass
// gravity gradient tensor pipeline.
// ============================================================================
package ggt_pkg;

    localparam int POS_W  = 48;   // position and origin coordinates
    localparam int MU_W   = 52;   // gravitational parameter
    localparam int OUT_W  = 64;   // tensor entries
    localparam int AN_W   = 30;   // normalized component magnitude
    localparam int PR_W   = 60;   // component product
    localparam int S_W    = 62;   // sum of squares, also 3x product
    localparam int ROOT_W = 62;   // scaled root
    localparam int W_W    = 124;  // S * root
    localparam int WT_W   = 63;   // truncated S * root
    localparam int Q_W    = 64;   // reciprocal
    localparam int MQ_W   = 116;  // mu * reciprocal
    localparam int C_W    = 63;   // entry ratio
    localparam int P_W    = 127;  // m * ratio
    localparam int E_W    = 6;    // bit length codes
    localparam int EX_W   = 9;    // output exponent
    localparam int NENT   = 6;    // distinct entries

    // register stages of each part
    localparam int FRONT_LAT = 6;
    localparam int LAT_TOTAL = 139;
    localparam int SIDE_DLY  = 132;  // front side band to the final stage
    localparam int C_DLY     = 67;   // ratio divider output to the m * c stage

    // configuration register indexes
    localparam logic [1:0] CFG_GRAV     = 2'd0;
    localparam logic [1:0] CFG_ORIGIN_X = 2'd1;
    localparam logic [1:0] CFG_ORIGIN_Y = 2'd2;
    localparam logic [1:0] CFG_ORIGIN_Z = 2'd3;

    localparam logic [MU_W-1:0] GRAV_RESET = 52'd398600441800000;

    // entry order xx, xy, xz, yy, yz, zz
    localparam int PAIR_I [NENT] = '{0, 0, 0, 1, 1, 2};
    localparam int PAIR_J [NENT] = '{0, 1, 2, 1, 2, 2};

    // per-word side band carried to the output stage
    typedef struct packed {
        logic [E_W-1:0]  blen;   // bit length of the largest component
        logic            zero;   // relative position is zero
        logic [NENT-1:0] neg;    // sign of each entry before the ratio test
    } t_side;

    // position of the highest set bit plus one, zero for zero
    function automatic logic [E_W-1:0] bit_len(input logic [MU_W-1:0] x);
        logic [E_W-1:0] n;
        n = '0;
        for (int i = 0; i < MU_W; i++) begin
            if (x[i]) begin
                n = E_W'(i + 1);
            end
        end
        return n;
    endfunction

endpackage

// File: design/ggt_delay.sv
// ============================================================================
// ggt_delay
// Enabled shift line that keeps side data aligned with the long pipeline.
// ============================================================================
module ggt_delay
    import ggt_pkg::*;
#(
    parameter int WIDTH = 8,
    parameter int DEPTH = 2
) (
    input  logic             i_clk,
    input  logic             i_en,
    input  logic [WIDTH-1:0] i_data,
    output logic [WIDTH-1:0] o_data
);

    logic [WIDTH-1:0] r_tap [DEPTH];

    // shift one place per advance
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_tap[0] <= i_data;
            for (int i = 1; i < DEPTH; i++) begin
                r_tap[i] <= r_tap[i-1];
            end
        end
    end

    assign o_data = r_tap[DEPTH-1];

endmodule

// File: design/ggt_div.sv
// ============================================================================
// ggt_div
// Pipelined restoring divider, one quotient bit per register stage.
// The starting remainder must be below the divisor; the bit vector is
// shifted in from its top bit.
// ============================================================================
module ggt_div
    import ggt_pkg::*;
#(
    parameter int RW = 62,
    parameter int QW = 63
) (
    input  logic          i_clk,
    input  logic          i_en,
    input  logic [RW-1:0] i_rem,
    input  logic [QW-1:0] i_bits,
    input  logic [RW-1:0] i_den,
    output logic [QW-1:0] o_quo
);

    logic [RW-1:0] r_rem  [QW];
    logic [QW-1:0] r_bits [QW];
    logic [RW-1:0] r_den  [QW];
    logic [QW-1:0] r_quo  [QW];

    genvar k;
    for (k = 0; k < QW; k++) begin : g_stage
        logic [RW-1:0] w_rem_in;
        logic [QW-1:0] w_bits_in;
        logic [RW-1:0] w_den_in;
        logic [QW-1:0] w_quo_in;
        logic [RW:0]   w_trial;
        logic          w_take;

        if (k == 0) begin : g_first
            assign w_rem_in  = i_rem;
            assign w_bits_in = i_bits;
            assign w_den_in  = i_den;
            assign w_quo_in  = '0;
        end else begin : g_next
            assign w_rem_in  = r_rem[k-1];
            assign w_bits_in = r_bits[k-1];
            assign w_den_in  = r_den[k-1];
            assign w_quo_in  = r_quo[k-1];
        end

        // bring down one bit, subtract when it fits
        assign w_trial = {w_rem_in, w_bits_in[QW-1-k]};
        assign w_take  = (w_trial >= {1'b0, w_den_in});

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_rem[k]  <= w_take ? RW'(w_trial - {1'b0, w_den_in}) : w_trial[RW-1:0];
                r_bits[k] <= w_bits_in;
                r_den[k]  <= w_den_in;
                r_quo[k]  <= {w_quo_in[QW-2:0], w_take};
            end
        end
    end

    assign o_quo = r_quo[QW-1];

endmodule

// File: design/ggt_sqrt.sv
// ============================================================================
// ggt_sqrt
// Pipelined digit-by-digit square root of S * 2^62, one root bit per stage.
// The radicand travels alongside and leaves with its root.
// ============================================================================
module ggt_sqrt
    import ggt_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_en,
    input  logic [S_W-1:0]    i_rad,
    output logic [S_W-1:0]    o_rad,
    output logic [ROOT_W-1:0] o_root
);

    logic [63:0]       r_rem  [ROOT_W];
    logic [ROOT_W-1:0] r_root [ROOT_W];
    logic [S_W-1:0]    r_rad  [ROOT_W];

    genvar k;
    for (k = 0; k < ROOT_W; k++) begin : g_stage
        localparam int PAIR = ROOT_W - 1 - k;
        logic [63:0]       w_rem_in;
        logic [ROOT_W-1:0] w_root_in;
        logic [S_W-1:0]    w_rad_in;
        logic [123:0]      w_num;
        logic [65:0]       w_cur;
        logic [65:0]       w_try;
        logic              w_take;

        if (k == 0) begin : g_first
            assign w_rem_in  = '0;
            assign w_root_in = '0;
            assign w_rad_in  = i_rad;
        end else begin : g_next
            assign w_rem_in  = r_rem[k-1];
            assign w_root_in = r_root[k-1];
            assign w_rad_in  = r_rad[k-1];
        end

        // next two radicand bits against 4*root + 1
        assign w_num  = {w_rad_in, 62'd0};
        assign w_cur  = {w_rem_in, w_num[2*PAIR +: 2]};
        assign w_try  = {2'b00, w_root_in, 2'b01};
        assign w_take = (w_cur >= w_try);

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_rem[k]  <= w_take ? 64'(w_cur - w_try) : w_cur[63:0];
                r_root[k] <= {w_root_in[ROOT_W-2:0], w_take};
                r_rad[k]  <= w_rad_in;
            end
        end
    end

    assign o_root = r_root[ROOT_W-1];
    assign o_rad  = r_rad[ROOT_W-1];

endmodule

// File: design/ggt_front.sv
// ============================================================================
// ggt_front
// Six front stages: relative position, normalization, component products,
// sum of squares and the signed numerator of every entry.
// ============================================================================
module ggt_front
    import ggt_pkg::*;
(
    input  logic                    i_clk,
    input  logic                    i_en,
    input  logic signed [POS_W-1:0] i_pos    [3],
    input  logic signed [POS_W-1:0] i_origin [3],
    output logic [S_W-1:0]          o_sum,        // one stage ahead of o_num
    output logic [S_W-1:0]          o_num    [NENT],
    output t_side                   o_side
);

    // stage 1
    logic [POS_W-1:0] r_abs1 [3];
    logic [2:0]       r_neg1;
    // stage 2
    logic [POS_W-1:0] r_abs2 [3];
    logic [2:0]       r_neg2;
    logic [E_W-1:0]   r_blen2;
    // stage 3
    logic [AN_W-1:0]  r_a3 [3];
    logic [2:0]       r_neg3;
    logic [E_W-1:0]   r_blen3;
    // stage 4
    logic [PR_W-1:0]  r_pr4 [NENT];
    logic [2:0]       r_neg4;
    logic [E_W-1:0]   r_blen4;
    // stage 5
    logic [PR_W-1:0]  r_pr5 [NENT];
    logic [S_W-1:0]   r_sum5;
    logic [2:0]       r_neg5;
    logic [E_W-1:0]   r_blen5;
    // stage 6
    logic [S_W-1:0]   r_num6 [NENT];
    t_side            r_side6;

    logic [POS_W-1:0] w_max;

    // stage 1: d = pos - origin, magnitude and sign
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            for (int i = 0; i < 3; i++) begin
                logic [POS_W:0] d;
                d = {i_pos[i][POS_W-1], i_pos[i]} - {i_origin[i][POS_W-1], i_origin[i]};
                r_neg1[i] <= d[POS_W];
                r_abs1[i] <= d[POS_W] ? POS_W'(-d) : d[POS_W-1:0];
            end
        end
    end

    // stage 2: bit length of the largest magnitude
    always_comb begin
        w_max = r_abs1[0];
        if (r_abs1[1] > w_max) begin
            w_max = r_abs1[1];
        end
        if (r_abs1[2] > w_max) begin
            w_max = r_abs1[2];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_abs2  <= r_abs1;
            r_neg2  <= r_neg1;
            r_blen2 <= bit_len(MU_W'(w_max));
        end
    end

    // stage 3: bring the largest into [2^29, 2^30)
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            for (int i = 0; i < 3; i++) begin
                if (r_blen2 <= E_W'(AN_W)) begin
                    r_a3[i] <= AN_W'(r_abs2[i] << (E_W'(AN_W) - r_blen2));
                end else begin
                    r_a3[i] <= AN_W'(r_abs2[i] >> (r_blen2 - E_W'(AN_W)));
                end
            end
            r_neg3  <= r_neg2;
            r_blen3 <= r_blen2;
        end
    end

    // stage 4: component products
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            for (int n = 0; n < NENT; n++) begin
                r_pr4[n] <= PR_W'(r_a3[PAIR_I[n]]) * PR_W'(r_a3[PAIR_J[n]]);
            end
            r_neg4  <= r_neg3;
            r_blen4 <= r_blen3;
        end
    end

    // stage 5: sum of squares
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_sum5  <= S_W'(r_pr4[0]) + S_W'(r_pr4[3]) + S_W'(r_pr4[5]);
            r_pr5   <= r_pr4;
            r_neg5  <= r_neg4;
            r_blen5 <= r_blen4;
        end
    end

    // stage 6: numerator magnitude and sign per entry
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            for (int n = 0; n < NENT; n++) begin
                logic [S_W-1:0] t;
                t = {1'b0, r_pr5[n], 1'b0} + {2'b00, r_pr5[n]};
                if (PAIR_I[n] == PAIR_J[n]) begin
                    r_side6.neg[n] <= (t < r_sum5);
                    r_num6[n]      <= (t < r_sum5) ? (r_sum5 - t) : (t - r_sum5);
                end else begin
                    r_side6.neg[n] <= r_neg5[PAIR_I[n]] ^ r_neg5[PAIR_J[n]];
                    r_num6[n]      <= t;
                end
            end
            r_side6.blen <= r_blen5;
            r_side6.zero <= (r_blen5 == '0);
        end
    end

    assign o_sum  = r_sum5;
    assign o_num  = r_num6;
    assign o_side = r_side6;

endmodule

// File: design/gravity_gradient_tensor.sv
// ============================================================================
// gravity_gradient_tensor
// Point-mass gravity gradient tensor, fully pipelined.
// ============================================================================
// Takes one position word per clock and returns the six distinct entries of
// mu/|r|^5 * (3 r r^T - |r|^2 I) for r = position - origin, saturated to
// 64-bit fixed point (2^-56 s^-2). Its depth comes mostly from the bit-per-stage
// root (62 stages), the reciprocal divider (64 stages) and the ratio dividers
// (63 stages, running beside the root). Throughput is one word per cycle;
// when the output word is not taken the whole pipeline holds and the input
// is not ready. A zero relative position gives zero entries and tuser bit 0
// set; a zero mu gives zero entries. Configuration must be written only while
// no word is in flight; the block itself does not enforce this.
// ============================================================================
module gravity_gradient_tensor
    import ggt_pkg::*;
(
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    // configuration
    input  logic                    i_cfg_we,
    input  logic [1:0]              i_cfg_addr,
    input  logic [MU_W-1:0]         i_cfg_wdata,
    // input stream
    input  logic                    i_s_axis_tvalid,
    output logic                    o_s_axis_tready,
    input  logic [3*POS_W-1:0]      i_s_axis_tdata,  // pos_x, pos_y, pos_z
    // output stream
    output logic                    o_m_axis_tvalid,
    input  logic                    i_m_axis_tready,
    output logic [NENT*OUT_W-1:0]   o_m_axis_tdata,  // t_xx, t_xy, t_xz, t_yy, t_yz, t_zz
    output logic [0:0]              o_m_axis_tuser   // zero_range
);

    logic [MU_W-1:0]         r_grav;
    logic signed [POS_W-1:0] r_origin [3];
    logic [LAT_TOTAL-1:0]    r_valid;
    logic                    w_en;

    logic signed [POS_W-1:0] w_pos [3];
    logic [S_W-1:0]          w_sum;
    logic [S_W-1:0]          r_sum6;
    logic [S_W-1:0]          w_num [NENT];
    t_side                   w_side6;
    t_side                   w_side;
    logic [S_W-1:0]          w_rad;
    logic [ROOT_W-1:0]       w_root;
    logic [C_W-1:0]          w_c  [NENT];
    logic [C_W-1:0]          w_cd [NENT];
    logic [Q_W-1:0]          w_q;
    logic [E_W-1:0]          w_mu_len;
    logic signed [EX_W-1:0]  w_ex;

    logic [61:0]             r_wp_ll, r_wp_lh, r_wp_hl, r_wp_hh;
    logic [W_W-1:0]          r_w;
    logic [57:0]             r_mp_ll, r_mp_lh, r_mp_hl, r_mp_hh;
    logic [MQ_W-1:0]         r_mq;
    logic [Q_W-1:0]          r_m;
    logic [63:0]             r_cp_ll [NENT];
    logic [62:0]             r_cp_lh [NENT];
    logic [63:0]             r_cp_hl [NENT];
    logic [62:0]             r_cp_hh [NENT];
    logic [NENT-1:0]         r_cnz1, r_cnz2;
    logic [P_W-1:0]          r_p [NENT];
    logic [OUT_W-1:0]        r_out [NENT];
    logic                    r_out_zero;

    // global advance: the pipeline moves unless the output word is held
    assign w_en            = ~r_valid[LAT_TOTAL-1] | i_m_axis_tready;
    assign o_s_axis_tready = w_en;
    assign o_m_axis_tvalid = r_valid[LAT_TOTAL-1];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= '0;
        end else if (w_en) begin
            r_valid <= {r_valid[LAT_TOTAL-2:0], i_s_axis_tvalid};
        end
    end

    // configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_grav      <= GRAV_RESET;
            r_origin[0] <= '0;
            r_origin[1] <= '0;
            r_origin[2] <= '0;
        end else if (i_cfg_we) begin
            case (i_cfg_addr)
                CFG_GRAV:     r_grav      <= i_cfg_wdata;
                CFG_ORIGIN_X: r_origin[0] <= i_cfg_wdata[POS_W-1:0];
                CFG_ORIGIN_Y: r_origin[1] <= i_cfg_wdata[POS_W-1:0];
                CFG_ORIGIN_Z: r_origin[2] <= i_cfg_wdata[POS_W-1:0];
                default: ;
            endcase
        end
    end

    assign w_pos[0] = i_s_axis_tdata[POS_W-1:0];
    assign w_pos[1] = i_s_axis_tdata[2*POS_W-1:POS_W];
    assign w_pos[2] = i_s_axis_tdata[3*POS_W-1:2*POS_W];

    ggt_front u_front (
        .i_clk    (i_clk),
        .i_en     (w_en),
        .i_pos    (w_pos),
        .i_origin (r_origin),
        .o_sum    (w_sum),
        .o_num    (w_num),
        .o_side   (w_side6)
    );

    ggt_sqrt u_sqrt (
        .i_clk  (i_clk),
        .i_en   (w_en),
        .i_rad  (w_sum),
        .o_rad  (w_rad),
        .o_root (w_root)
    );

    // sum of squares aligned with the entry numerators
    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_sum6 <= w_sum;
        end
    end

    // ratio dividers c = num * 2^61 / S, side by side with the root
    genvar n;
    for (n = 0; n < NENT; n++) begin : g_ratio
        ggt_div #(.RW(S_W), .QW(C_W)) u_div (
            .i_clk  (i_clk),
            .i_en   (w_en),
            .i_rem  ({2'b00, w_num[n][S_W-1:2]}),
            .i_bits ({w_num[n][1:0], 61'd0}),
            .i_den  (r_sum6),
            .o_quo  (w_c[n])
        );

        ggt_delay #(.WIDTH(C_W), .DEPTH(C_DLY)) u_cdly (
            .i_clk  (i_clk),
            .i_en   (w_en),
            .i_data (w_c[n]),
            .o_data (w_cd[n])
        );
    end

    ggt_delay #(.WIDTH($bits(t_side)), .DEPTH(SIDE_DLY)) u_side_dly (
        .i_clk  (i_clk),
        .i_en   (w_en),
        .i_data (w_side6),
        .o_data (w_side)
    );

    // S * root in four partial products, then their sum
    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_wp_ll <= 62'(w_rad[30:0])  * 62'(w_root[30:0]);
            r_wp_lh <= 62'(w_rad[30:0])  * 62'(w_root[61:31]);
            r_wp_hl <= 62'(w_rad[61:31]) * 62'(w_root[30:0]);
            r_wp_hh <= 62'(w_rad[61:31]) * 62'(w_root[61:31]);
            r_w     <= {r_wp_hh, 62'd0}
                     + ((W_W'(r_wp_lh) + W_W'(r_wp_hl)) << 31)
                     + W_W'(r_wp_ll);
        end
    end

    // q = (2^121 - 1) / floor(S * root / 2^61)
    ggt_div #(.RW(WT_W), .QW(Q_W)) u_recip (
        .i_clk  (i_clk),
        .i_en   (w_en),
        .i_rem  ({6'd0, {57{1'b1}}}),
        .i_bits ({Q_W{1'b1}}),
        .i_den  (r_w[W_W-1:61]),
        .o_quo  (w_q)
    );

    // m = mu * q / 2^bitlen(mu)
    assign w_mu_len = bit_len(r_grav);

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_mp_ll <= 58'(r_grav[25:0])  * 58'(w_q[31:0]);
            r_mp_lh <= 58'(r_grav[25:0])  * 58'(w_q[63:32]);
            r_mp_hl <= 58'(r_grav[51:26]) * 58'(w_q[31:0]);
            r_mp_hh <= 58'(r_grav[51:26]) * 58'(w_q[63:32]);
            r_mq    <= {r_mp_hh, 58'd0} + (MQ_W'(r_mp_lh) << 32)
                     + (MQ_W'(r_mp_hl) << 26) + MQ_W'(r_mp_ll);
            r_m     <= Q_W'(r_mq >> w_mu_len);
        end
    end

    // m * c per entry
    always_ff @(posedge i_clk) begin
        if (w_en) begin
            for (int k = 0; k < NENT; k++) begin
                r_cp_ll[k] <= 64'(r_m[31:0])  * 64'(w_cd[k][31:0]);
                r_cp_lh[k] <= 63'(r_m[31:0])  * 63'(w_cd[k][62:32]);
                r_cp_hl[k] <= 64'(r_m[63:32]) * 64'(w_cd[k][31:0]);
                r_cp_hh[k] <= 63'(r_m[63:32]) * 63'(w_cd[k][62:32]);
                r_cnz1[k]  <= (w_cd[k] != '0);
                r_p[k]     <= {r_cp_hh[k], 64'd0}
                            + ((P_W'(r_cp_lh[k]) + P_W'(r_cp_hl[k])) << 32)
                            + P_W'(r_cp_ll[k]);
            end
            r_cnz2 <= r_cnz1;
        end
    end

    // exponent b - 3e - 18
    assign w_ex = $signed(EX_W'({3'b000, w_mu_len}) - EX_W'({3'b000, w_side.blen}) * 9'd3
                          - 9'd18);

    // scale by 2^ex, saturate, apply sign
    function automatic logic [OUT_W-1:0] scale_out(input logic [P_W-1:0]        p,
                                                   input logic signed [EX_W-1:0] ex,
                                                   input logic                   neg);
        logic [P_W-1:0]   lim;
        logic [P_W-1:0]   shr;
        logic [EX_W-1:0]  k;
        logic [OUT_W-1:0] mag;
        lim = neg ? {63'd0, 1'b1, 63'd0} : {64'd0, {63{1'b1}}};
        if (ex < 0) begin
            k   = EX_W'(-ex);
            shr = p >> k;
            mag = (shr > lim) ? lim[OUT_W-1:0] : shr[OUT_W-1:0];
        end else begin
            mag = (p > (lim >> ex[4:0])) ? lim[OUT_W-1:0] : OUT_W'(p << ex[4:0]);
        end
        return neg ? (~mag + 64'd1) : mag;
    endfunction

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            for (int k = 0; k < NENT; k++) begin
                if (w_side.zero || (r_grav == '0)) begin
                    r_out[k] <= '0;
                end else begin
                    r_out[k] <= scale_out(r_p[k], w_ex, w_side.neg[k] & r_cnz2[k]);
                end
            end
            r_out_zero <= w_side.zero;
        end
    end

    assign o_m_axis_tdata = {r_out[5], r_out[4], r_out[3], r_out[2], r_out[1], r_out[0]};
    assign o_m_axis_tuser = r_out_zero;

    // zero relative position always leaves all entries zero
    a_zero_entries: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid && o_m_axis_tuser[0] |-> o_m_axis_tdata == '0)
        else $error("zero_range word with nonzero entries");

    // a held output word freezes the whole pipeline
    a_stall_freeze: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid && !i_m_axis_tready |=> $stable(r_valid) && $stable(r_out_zero))
        else $error("pipeline moved during output stall");

    // no word leaves right after reset
    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_m_axis_tvalid)
        else $error("output valid after reset");

endmodule

// File: tb/tb_gravity_gradient_tensor.sv
`timescale 1ns / 1ps
// ============================================================================
// tb_gravity_gradient_tensor
// Self-checking bench for the point-mass gravity gradient tensor pipeline.
// ============================================================================
// A directed table covers the zero range, the coordinate extremes and small
// vectors under the reset configuration. Random phases follow, most under a
// new mu and origin, among them mu = 0, mu at full scale and origins at both
// ends. Every output word is compared with a typed zero-range word or with a
// bit-exact fixed-point model of the tensor. Both stream sides idle in random
// bursts except in the closing stretch.
// ============================================================================
module tb_gravity_gradient_tensor;
    import ggt_pkg::*;

    localparam logic [POS_W-1:0] P_MAX = {1'b0, {(POS_W-1){1'b1}}};
    localparam logic [POS_W-1:0] P_MIN = {1'b1, {(POS_W-1){1'b0}}};
    localparam logic [POS_W-1:0] P_M1  = {POS_W{1'b1}};
    localparam int CYCLE_LIMIT = 400000;

    typedef struct packed {
        logic                      zr;
        logic [NENT-1:0][OUT_W-1:0] t;
    } t_tensor;

    typedef struct {
        logic [POS_W-1:0] x, y, z;
        bit               known_zero;   // expected words typed in: zero range
    } t_row;

    logic                  i_clk = 1'b0;
    logic                  i_rst_n = 1'b0;
    logic                  i_cfg_we = 1'b0;
    logic [1:0]            i_cfg_addr = CFG_GRAV;
    logic [MU_W-1:0]       i_cfg_wdata = '0;
    logic                  i_s_axis_tvalid = 1'b0;
    logic                  o_s_axis_tready;
    logic [3*POS_W-1:0]    i_s_axis_tdata = '0;   // pos_x, pos_y, pos_z
    logic                  o_m_axis_tvalid;
    logic                  i_m_axis_tready = 1'b0;
    logic [NENT*OUT_W-1:0] o_m_axis_tdata;        // t_xx, t_xy, t_xz, t_yy, t_yz, t_zz
    logic [0:0]            o_m_axis_tuser;        // zero_range

    gravity_gradient_tensor dut (.*);

    always #5 i_clk = ~i_clk;

    // local copy of the configuration
    logic [MU_W-1:0]  mu_reg = GRAV_RESET;
    logic [POS_W-1:0] org_reg [3] = '{default: '0};

    t_tensor pending_tensors [$];
    int  n_mismatch = 0;
    int  n_words = 0;
    int  n_sent = 0;
    int  n_zero_seen = 0;
    int  n_sat_seen = 0;
    int  cycles = 0;
    bit  quiet = 1'b0;

    function automatic int bit_count_len(input logic [127:0] x);
        int n;
        n = 0;
        for (int i = 0; i < 128; i++) begin
            if (x[i]) begin
                n = i + 1;
            end
        end
        return n;
    endfunction

    // bit-exact fixed-point gradient tensor for one position
    function automatic t_tensor calc_gradient(input logic [POS_W-1:0] px, py, pz);
        t_tensor          res;
        logic [POS_W-1:0] p [3];
        logic [63:0]      dv, s, tt, gm;
        logic [63:0]      a [3];
        logic             ng [3];
        logic [127:0]     mx, r, rc, w, wt, q, mq, m, c, prod, mag, lim;
        logic             gn, ngo;
        int               e, sh, b, ex, x, y;
        res = '0;
        p[0] = px; p[1] = py; p[2] = pz;
        mx = '0;
        s = '0;
        for (int i = 0; i < 3; i++) begin
            dv = {{16{p[i][POS_W-1]}}, p[i]} - {{16{org_reg[i][POS_W-1]}}, org_reg[i]};
            ng[i] = dv[63];
            a[i] = ng[i] ? -dv : dv;
            if (a[i] > mx) begin
                mx = a[i];
            end
        end
        if (mx == 0) begin
            res.zr = 1'b1;
            return res;
        end
        e = bit_count_len(mx);
        sh = 30 - e;
        for (int i = 0; i < 3; i++) begin
            a[i] = (sh >= 0) ? (a[i] << sh) : (a[i] >> (-sh));
            s += a[i] * a[i];
        end
        if (mu_reg == 0) begin
            return res;
        end
        // floor(sqrt(S * 2^62)), one bit per step
        r = '0;
        for (int i = 62; i >= 0; i--) begin
            rc = r | (128'd1 << i);
            if (rc * rc <= ({64'd0, s} << 62)) begin
                r = rc;
            end
        end
        w = {64'd0, s} * r;
        wt = {64'd0, 64'(w >> 61)};
        q = ((128'd1 << 121) - 128'd1) / wt;
        q = {64'd0, q[63:0]};
        b = bit_count_len({76'd0, mu_reg});
        mq = {76'd0, mu_reg} * q;
        m = {64'd0, 64'(mq >> b)};
        ex = 3 * sh + b - 108;
        for (int k = 0; k < NENT; k++) begin
            x = PAIR_I[k];
            y = PAIR_J[k];
            if (x == y) begin
                tt = 64'd3 * a[x] * a[x];
                gn = tt < s;
                gm = gn ? (s - tt) : (tt - s);
            end else begin
                gm = 64'd3 * a[x] * a[y];
                gn = ng[x] != ng[y];
            end
            c = ({64'd0, gm} << 61) / {64'd0, s};
            c = {64'd0, c[63:0]};
            prod = m * c;
            ngo = gn && (c != 0);
            lim = ngo ? (128'd1 << 63) : ((128'd1 << 63) - 128'd1);
            if (ex < 0) begin
                mag = (-ex >= 128) ? 128'd0 : (prod >> (-ex));
                if (mag > lim) begin
                    mag = lim;
                end
            end else begin
                mag = (prod > (lim >> ex)) ? lim : (prod << ex);
            end
            res.t[k] = ngo ? -mag[63:0] : mag[63:0];
        end
        return res;
    endfunction

    // cycle limit
    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT) begin
            $display("timeout after %0d cycles, %0d words pending", cycles,
                     pending_tensors.size());
            $display("tb: failure");
            $finish;
        end
    end

    // output side backpressure in random bursts
    int stall_left = 0;
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_m_axis_tready <= 1'b0;
        end else if (quiet) begin
            i_m_axis_tready <= 1'b1;
        end else if (stall_left > 0) begin
            stall_left <= stall_left - 1;
            i_m_axis_tready <= 1'b0;
        end else if ($urandom_range(0, 5) == 0) begin
            stall_left <= $urandom_range(1, 13) - 1;
            i_m_axis_tready <= 1'b0;
        end else begin
            i_m_axis_tready <= 1'b1;
        end
    end

    // compare each output word with the oldest expected tensor
    always @(posedge i_clk) begin
        t_tensor want, got;
        if (i_rst_n && o_m_axis_tvalid && i_m_axis_tready) begin
            got.t = o_m_axis_tdata;
            got.zr = o_m_axis_tuser[0];
            n_words++;
            if (got.zr) begin
                n_zero_seen++;
            end
            for (int k = 0; k < NENT; k++) begin
                if (got.t[k] == {1'b0, {63{1'b1}}} || got.t[k] == {1'b1, 63'd0}) begin
                    n_sat_seen++;
                end
            end
            if (pending_tensors.size() == 0) begin
                n_mismatch++;
                if (n_mismatch <= 10) begin
                    $display("unexpected output word %0d", n_words);
                end
            end else begin
                want = pending_tensors.pop_front();
                if (got !== want) begin
                    n_mismatch++;
                    if (n_mismatch <= 10) begin
                        $display("mismatch at word %0d", n_words);
                        $display("  exp zr=%0b t=%h", want.zr, want.t);
                        $display("  got zr=%0b t=%h", got.zr, got.t);
                    end
                end
            end
        end
    end

    // present one position and hold it until taken
    task automatic send_position(input logic [POS_W-1:0] px, py, pz, input bit typed);
        t_tensor want;
        if (!quiet && $urandom_range(0, 3) == 0) begin
            i_s_axis_tvalid <= 1'b0;
            repeat ($urandom_range(1, 13)) @(posedge i_clk);
        end
        i_s_axis_tvalid <= 1'b1;
        i_s_axis_tdata <= {pz, py, px};
        do @(posedge i_clk); while (!o_s_axis_tready);
        if (typed) begin
            want = '0;
            want.zr = 1'b1;
        end else begin
            want = calc_gradient(px, py, pz);
        end
        pending_tensors.push_back(want);
        n_sent++;
    endtask

    task automatic drain_pipeline();
        i_s_axis_tvalid <= 1'b0;
        while (pending_tensors.size() != 0) @(posedge i_clk);
        repeat (LAT_TOTAL + 10) @(posedge i_clk);
    endtask

    task automatic write_reg(input logic [1:0] addr, input logic [MU_W-1:0] data);
        i_cfg_we <= 1'b1;
        i_cfg_addr <= addr;
        i_cfg_wdata <= data;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        if (addr == CFG_GRAV) begin
            mu_reg = data;
        end else begin
            org_reg[addr - 1] = data[POS_W-1:0];
        end
    endtask

    function automatic logic [POS_W-1:0] rand_word();
        return POS_W'({$urandom, $urandom});
    endfunction

    // offset from the origin with a random bit length and sign
    function automatic logic [POS_W-1:0] rand_offset(input int axis);
        logic [POS_W-1:0] v;
        int nb;
        nb = $urandom_range(0, POS_W - 1);
        v = rand_word() & ((48'd1 << nb) - 48'd1);
        if ($urandom_range(0, 1) == 1) begin
            v = -v;
        end
        return org_reg[axis] + v;
    endfunction

    task automatic send_random(input int n_items);
        logic [POS_W-1:0] v [3];
        int mode;
        for (int i = 0; i < n_items; i++) begin
            mode = $urandom_range(0, 19);
            for (int j = 0; j < 3; j++) begin
                if (mode < 6) begin
                    v[j] = rand_word();
                end else if (mode == 19) begin
                    v[j] = org_reg[j];
                end else begin
                    v[j] = rand_offset(j);
                end
            end
            // one axis set to a random origin coordinate, or equal components
            if (mode >= 14 && mode < 17) begin
                v[$urandom_range(0, 2)] = org_reg[$urandom_range(0, 2)];
            end else if (mode == 17 || mode == 18) begin
                v[1] = v[0] - org_reg[0] + org_reg[1];
                v[2] = v[0] - org_reg[0] + org_reg[2];
            end
            send_position(v[0], v[1], v[2], 1'b0);
        end
    endtask

    t_row dir_rows [17];

    initial begin
        dir_rows = '{
            '{48'd0, 48'd0, 48'd0, 1'b1},
            '{P_MAX, 48'd0, 48'd0, 1'b0},
            '{48'd0, P_MAX, 48'd0, 1'b0},
            '{48'd0, 48'd0, P_MAX, 1'b0},
            '{P_MIN, 48'd0, 48'd0, 1'b0},
            '{48'd0, P_MIN, 48'd0, 1'b0},
            '{48'd0, 48'd0, P_MIN, 1'b0},
            '{P_MAX, P_MAX, P_MAX, 1'b0},
            '{P_MIN, P_MIN, P_MIN, 1'b0},
            '{P_MAX, P_MIN, P_MAX, 1'b0},
            '{48'd1, 48'd0, 48'd0, 1'b0},
            '{P_M1, 48'd1, P_M1, 1'b0},
            '{48'd1, 48'd1, 48'd1, 1'b0},
            '{48'd3, 48'd4, 48'd0, 1'b0},
            '{48'd1000, -48'd1000, 48'd1, 1'b0},
            '{48'h0000_6371_0000, 48'd0, 48'd0, 1'b0},
            '{48'd0, 48'd0, 48'd0, 1'b1}
        };
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // reset configuration: directed table, then random
        foreach (dir_rows[i]) begin
            send_position(dir_rows[i].x, dir_rows[i].y, dir_rows[i].z,
                          dir_rows[i].known_zero);
        end
        send_random(300);

        // full-scale mu, origin at the top corner; upper bits masked off
        drain_pipeline();
        write_reg(CFG_GRAV, {MU_W{1'b1}});
        write_reg(CFG_ORIGIN_X, {4'hF, P_MAX});
        write_reg(CFG_ORIGIN_Y, {4'hA, P_MAX});
        write_reg(CFG_ORIGIN_Z, {4'h5, P_MAX});
        send_random(200);

        // mu of zero gives zero entries
        drain_pipeline();
        write_reg(CFG_GRAV, '0);
        write_reg(CFG_ORIGIN_X, {4'h0, P_MIN});
        send_random(200);

        // smallest nonzero mu, origin at the bottom corner
        drain_pipeline();
        write_reg(CFG_GRAV, 52'd1);
        write_reg(CFG_ORIGIN_Y, {4'h0, P_MIN});
        write_reg(CFG_ORIGIN_Z, {4'h0, P_MIN});
        send_random(200);

        // random setting
        drain_pipeline();
        write_reg(CFG_GRAV, MU_W'({$urandom, $urandom}));
        write_reg(CFG_ORIGIN_X, MU_W'({$urandom, $urandom}));
        write_reg(CFG_ORIGIN_Y, MU_W'({$urandom, $urandom}));
        write_reg(CFG_ORIGIN_Z, MU_W'({$urandom, $urandom}));
        send_random(200);

        // Earth mu again, random origin in x and z; no idling at the end
        drain_pipeline();
        write_reg(CFG_GRAV, GRAV_RESET);
        write_reg(CFG_ORIGIN_X, MU_W'({$urandom, $urandom}));
        write_reg(CFG_ORIGIN_Y, 52'd0);
        write_reg(CFG_ORIGIN_Z, MU_W'({$urandom, $urandom}));
        send_random(50);
        quiet = 1'b1;
        send_random(150);

        drain_pipeline();
        $display("sent %0d positions over 6 settings, checked %0d words", n_sent, n_words);
        $display("zero-range words %0d, saturated entries %0d, mismatches %0d",
                 n_zero_seen, n_sat_seen, n_mismatch);
        if (n_mismatch == 0 && pending_tensors.size() == 0) begin
            $display("tb: success");
        end else begin
            $display("tb: failure");
        end
        $finish;
    end

endmodule
